[rtl/core/pts_pkg.sv]
`default_nettype none

package pts_pkg;

  localparam int unsigned CFG_WIDTH      = 32;
  localparam int unsigned REP_WIDTH      = 16;
  localparam int unsigned GATE_WIDTH     = 16;
  localparam int unsigned CMD_WIDTH      = 2;
  localparam int unsigned PADDR_WIDTH    = 4;
  localparam int unsigned TIME_WIDTH_DEF = 32;

  localparam logic [GATE_WIDTH-1:0] GATE_OPEN = GATE_WIDTH'(1);
  localparam logic [REP_WIDTH-1:0]  REP_RESET = REP_WIDTH'(1);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_ON   = 2'd2,
    PH_GAP  = 2'd3
  } phase_e;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_DELAY    = 2'd0,
    REG_DURATION = 2'd1,
    REG_PERIOD   = 2'd2,
    REG_REPEAT   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] delay_ticks;
    logic [CFG_WIDTH-1:0] duration_ticks;
    logic [CFG_WIDTH-1:0] period_ticks;
    logic [REP_WIDTH-1:0] repeat_count;
  } cfg_t;

  typedef struct packed {
    logic [CMD_WIDTH-1:0]  cmd;
    logic                  gate_present;
    logic [GATE_WIDTH-1:0] gate_value;
  } item_t;

  typedef struct packed {
    phase_e phase;
    logic   changed;
    logic   on_event;
    logic   off_event;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/pts_cfg_regs.sv]
`default_nettype none

module pts_cfg_regs
  import pts_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PADDR_WIDTH-1:0] paddr,
  input  wire logic [CFG_WIDTH-1:0]   pwdata,
  output      logic [CFG_WIDTH-1:0]   prdata,
  output      logic                   pready,
  output      cfg_t                   cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_DELAY:    cfg_d.delay_ticks    = pwdata;
        REG_DURATION: cfg_d.duration_ticks = pwdata;
        REG_PERIOD:   cfg_d.period_ticks   = pwdata;
        REG_REPEAT:   cfg_d.repeat_count   = pwdata[REP_WIDTH-1:0];
        default:      cfg_d                = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DELAY:    prdata = cfg_q.delay_ticks;
      REG_DURATION: prdata = cfg_q.duration_ticks;
      REG_PERIOD:   prdata = cfg_q.period_ticks;
      REG_REPEAT:   prdata = CFG_WIDTH'(cfg_q.repeat_count);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_ticks    <= '0;
      cfg_q.duration_ticks <= '0;
      cfg_q.period_ticks   <= '0;
      cfg_q.repeat_count   <= REP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/pts_engine.sv]
`default_nettype none

module pts_engine
  import pts_pkg::*;
#(
  parameter int unsigned TimeWidth = TIME_WIDTH_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    step_i,
  input  wire item_t   item_i,
  input  wire cfg_t    cfg_i,
  output      result_t result_o
);

  localparam int unsigned CmpWidth = (TimeWidth > CFG_WIDTH) ? TimeWidth : CFG_WIDTH;

  phase_e                phase_q, phase_d;
  logic [TimeWidth-1:0]  elapsed_q, elapsed_d;
  logic [REP_WIDTH-1:0]  repeats_q, repeats_d;

  logic [TimeWidth-1:0]  elapsed_inc;
  logic [CmpWidth-1:0]   et;
  logic [CFG_WIDTH-1:0]  gap_ticks;
  logic [REP_WIDTH-1:0]  repeats_dec;
  cmd_e                  cmd;

  assign cmd         = cmd_e'(item_i.cmd);
  assign elapsed_inc = (elapsed_q == {TimeWidth{1'b1}}) ? elapsed_q
                                                         : elapsed_q + TimeWidth'(1);
  assign et          = CmpWidth'(elapsed_inc);
  assign gap_ticks   = cfg_i.period_ticks - cfg_i.duration_ticks;
  assign repeats_dec = (repeats_q != '0) ? repeats_q - REP_WIDTH'(1) : '0;

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    repeats_d = repeats_q;
    result_o  = '{phase: phase_q, changed: 1'b0, on_event: 1'b0, off_event: 1'b0};
    case (cmd)
      CMD_START: begin
        elapsed_d = '0;
        phase_d   = PH_WAIT;
      end
      CMD_STOP: begin
        phase_d = PH_IDLE;
      end
      CMD_TICK: begin
        elapsed_d = elapsed_inc;
        case (phase_q)
          PH_WAIT: begin
            if (et >= CmpWidth'(cfg_i.delay_ticks)) begin
              repeats_d         = cfg_i.repeat_count;
              phase_d           = PH_ON;
              result_o.on_event = !(item_i.gate_present && item_i.gate_value != GATE_OPEN);
              elapsed_d         = '0;
              result_o.changed  = 1'b1;
            end
          end
          PH_ON: begin
            if (et >= CmpWidth'(cfg_i.duration_ticks)) begin
              repeats_d          = repeats_dec;
              phase_d            = (repeats_dec == '0) ? PH_IDLE : PH_GAP;
              result_o.off_event = 1'b1;
              elapsed_d          = '0;
              result_o.changed   = 1'b1;
            end
          end
          PH_GAP: begin
            if (et >= CmpWidth'(gap_ticks)) begin
              phase_d           = PH_ON;
              result_o.on_event = 1'b1;
              elapsed_d         = '0;
              result_o.changed  = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    result_o.phase = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      elapsed_q <= '0;
      repeats_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      repeats_q <= repeats_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/pulse_train_sequencer.sv]
// An accepted word is captured in the input register; its result is then registered in
// the result register when the engine steps, which waits while the output is stalled.
// Throughput: one word per cycle while the output is not stalled; the input and result
// registers form a two-stage pipeline; the state update is a single compare and increment.
// Reset (rst_ni low, asynchronous): phase idle, elapsed count and repeats cleared,
// configuration at its reset values, both pipeline stages empty.
`default_nettype none

module pulse_train_sequencer
  import pts_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire logic [CMD_WIDTH-1:0]   cmd_i,
  input  wire logic                   gate_present_i,
  input  wire logic [GATE_WIDTH-1:0]  gate_value_i,
  output      logic                   out_valid_o,
  input  wire logic                   out_ready_i,
  output      logic [1:0]             phase_o,
  output      logic                   changed_o,
  output      logic                   on_event_o,
  output      logic                   off_event_o,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PADDR_WIDTH-1:0] paddr,
  input  wire logic [CFG_WIDTH-1:0]   pwdata,
  output      logic [CFG_WIDTH-1:0]   prdata,
  output      logic                   pready
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_valid_q;
  result_t res_d, res_q;
  logic    res_valid_q;
  logic    step;

  pts_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pts_engine #(
    .TimeWidth (TIME_WIDTH)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  assign step       = item_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (step) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= '{cmd: cmd_i, gate_present: gate_present_i, gate_value: gate_value_i};
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign phase_o     = res_q.phase;
  assign changed_o   = res_q.changed;
  assign on_event_o  = res_q.on_event;
  assign off_event_o = res_q.off_event;

endmodule

`default_nettype wire

[rtl/core/pts_checker.sv]
`default_nettype none

module pts_assertions
  import pts_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [1:0] phase_o,
  input wire logic       changed_o,
  input wire logic       on_event_o,
  input wire logic       off_event_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(phase_o) && $stable(changed_o)
      && $stable(on_event_o) && $stable(off_event_o))
    else $error("result word changed while stalled");

  a_event_changed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (on_event_o || off_event_o) |-> changed_o)
    else $error("switch event without a phase change");

  a_on_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && on_event_o |-> phase_o == PH_ON && !off_event_o)
    else $error("on event outside the pulse phase");

  a_off_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && off_event_o |-> phase_o == PH_IDLE || phase_o == PH_GAP)
    else $error("off event into a phase other than idle or gap");

endmodule

bind pulse_train_sequencer pts_assertions u_pts_assertions (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .phase_o     (phase_o),
  .changed_o   (changed_o),
  .on_event_o  (on_event_o),
  .off_event_o (off_event_o)
);

`default_nettype wire

[verif/pts_checker.sv]
`default_nettype none

module pts_checker
  import pts_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_ready_i,
  input  wire logic [CMD_WIDTH-1:0]   cmd_i,
  input  wire logic                   gate_present_i,
  input  wire logic [GATE_WIDTH-1:0]  gate_value_i,
  input  wire logic                   out_valid_i,
  input  wire logic                   out_ready_i,
  input  wire logic [1:0]             phase_i,
  input  wire logic                   changed_i,
  input  wire logic                   on_event_i,
  input  wire logic                   off_event_i,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PADDR_WIDTH-1:0] paddr,
  input  wire logic [CFG_WIDTH-1:0]   pwdata,
  input  wire logic                   pready,
  output int                          error_count_o,
  output int                          words_in_flight_o
);

  logic [CFG_WIDTH-1:0]  delay_ticks;
  logic [CFG_WIDTH-1:0]  duration_ticks;
  logic [CFG_WIDTH-1:0]  period_ticks;
  logic [REP_WIDTH-1:0]  repeat_count;
  phase_e                train_phase;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [REP_WIDTH-1:0]  repeats_left;
  result_t               train_reports[$];

  function automatic result_t advance_train(input logic [CMD_WIDTH-1:0] cmd,
                                            input logic gate_present,
                                            input logic [GATE_WIDTH-1:0] gate_value);
    result_t              rep;
    logic [CFG_WIDTH-1:0] gap_ticks;
    rep = '{phase: PH_IDLE, changed: 1'b0, on_event: 1'b0, off_event: 1'b0};
    gap_ticks = period_ticks - duration_ticks;
    case (cmd)
      CMD_START: begin
        elapsed = '0;
        train_phase = PH_WAIT;
      end
      CMD_STOP: begin
        train_phase = PH_IDLE;
      end
      CMD_TICK: begin
        if (elapsed != '1) begin
          elapsed = elapsed + 1'b1;
        end
        if (train_phase == PH_WAIT && elapsed >= delay_ticks) begin
          repeats_left = repeat_count;
          train_phase = PH_ON;
          rep.on_event = !(gate_present && gate_value != GATE_OPEN);
          elapsed = '0;
          rep.changed = 1'b1;
        end else if (train_phase == PH_ON && elapsed >= duration_ticks) begin
          if (repeats_left != '0) begin
            repeats_left = repeats_left - 1'b1;
          end
          train_phase = (repeats_left == '0) ? PH_IDLE : PH_GAP;
          rep.off_event = 1'b1;
          elapsed = '0;
          rep.changed = 1'b1;
        end else if (train_phase == PH_GAP && elapsed >= gap_ticks) begin
          train_phase = PH_ON;
          rep.on_event = 1'b1;
          elapsed = '0;
          rep.changed = 1'b1;
        end
      end
      default: begin
      end
    endcase
    rep.phase = train_phase;
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      delay_ticks = '0;
      duration_ticks = '0;
      period_ticks = '0;
      repeat_count = REP_RESET;
      train_phase = PH_IDLE;
      elapsed = '0;
      repeats_left = '0;
      train_reports.delete();
      error_count_o = 0;
      words_in_flight_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_DELAY:    delay_ticks = pwdata;
          REG_DURATION: duration_ticks = pwdata;
          REG_PERIOD:   period_ticks = pwdata;
          REG_REPEAT:   repeat_count = pwdata[REP_WIDTH-1:0];
          default: begin
          end
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (train_reports.size() == 0) begin
          $error("result word arrived with no prediction waiting");
          error_count_o++;
        end else begin
          want = train_reports.pop_front();
          if (want.phase != phase_i) begin
            $error("phase: expected %0d, got %0d", want.phase, phase_i);
            error_count_o++;
          end
          if (want.changed != changed_i) begin
            $error("changed: expected %0d, got %0d", want.changed, changed_i);
            error_count_o++;
          end
          if (want.on_event != on_event_i) begin
            $error("on_event: expected %0d, got %0d", want.on_event, on_event_i);
            error_count_o++;
          end
          if (want.off_event != off_event_i) begin
            $error("off_event: expected %0d, got %0d", want.off_event, off_event_i);
            error_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        train_reports.push_back(advance_train(cmd_i, gate_present_i, gate_value_i));
      end
      words_in_flight_o = train_reports.size();
    end
  end

endmodule

`default_nettype wire

[verif/testbench.sv]
`default_nettype none

module testbench;
  import pts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [CMD_WIDTH-1:0]   cmd_i;
  logic                   gate_present_i;
  logic [GATE_WIDTH-1:0]  gate_value_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [1:0]             phase_o;
  logic                   changed_o;
  logic                   on_event_o;
  logic                   off_event_o;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_WIDTH-1:0] paddr;
  logic [CFG_WIDTH-1:0]   pwdata;
  logic [CFG_WIDTH-1:0]   prdata;
  logic                   pready;
  int                     error_count;
  int                     words_in_flight;
  int                     sender_idle_pct;
  int                     stall_pct;
  int                     cycle_count;

  pulse_train_sequencer DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .gate_present_i, .gate_value_i,
    .out_valid_o, .out_ready_i, .phase_o, .changed_o, .on_event_o, .off_event_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pts_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .gate_present_i,
    .gate_value_i, .out_valid_i(out_valid_o), .out_ready_i, .phase_i(phase_o),
    .changed_i(changed_o), .on_event_i(on_event_o), .off_event_i(off_event_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .error_count_o(error_count), .words_in_flight_o(words_in_flight)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Every task below starts and returns at a falling edge.
  task automatic send_word(input logic [CMD_WIDTH-1:0] cmd, input logic gp,
                           input logic [GATE_WIDTH-1:0] gv);
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    gate_present_i <= gp;
    gate_value_i <= gv;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (words_in_flight != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [CFG_WIDTH-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_WIDTH'(4 * int'(idx));
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic program_train(input logic [CFG_WIDTH-1:0] delay,
                               input logic [CFG_WIDTH-1:0] duration,
                               input logic [CFG_WIDTH-1:0] period,
                               input logic [CFG_WIDTH-1:0] repeats);
    apb_write(REG_DELAY, delay);
    apb_write(REG_DURATION, duration);
    apb_write(REG_PERIOD, period);
    apb_write(REG_REPEAT, repeats);
  endtask

  initial begin
    int                    pick;
    logic [CMD_WIDTH-1:0]  cmd;
    logic [GATE_WIDTH-1:0] gv;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    cmd_i <= CMD_TICK;
    gate_present_i <= 1'b0;
    gate_value_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    sender_idle_pct = 0;
    stall_pct = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // With the reset settings a start gives a single pulse: on at the first tick, off at the next.
    send_word(CMD_TICK, 1'b0, 16'h0000);
    send_word(CMD_NOP, 1'b1, 16'hFFFF);
    send_word(CMD_START, 1'b0, 16'h0000);
    send_word(CMD_TICK, 1'b1, GATE_OPEN);
    send_word(CMD_TICK, 1'b0, 16'h0000);
    send_word(CMD_START, 1'b1, 16'h5A5A);
    send_word(CMD_TICK, 1'b1, 16'h0000);
    send_word(CMD_NOP, 1'b0, 16'h0001);
    send_word(CMD_START, 1'b0, 16'h0000);
    send_word(CMD_TICK, 1'b0, 16'hFFFF);
    send_word(CMD_STOP, 1'b1, 16'h0001);
    send_word(CMD_STOP, 1'b0, 16'h0000);
    send_word(CMD_START, 1'b0, 16'h0000);
    send_word(CMD_STOP, 1'b0, 16'h0000);
    send_word(CMD_TICK, 1'b1, 16'h8000);
    send_word(CMD_START, 1'b1, 16'hFFFF);
    send_word(CMD_TICK, 1'b1, 16'hFFFF);
    send_word(CMD_TICK, 1'b1, GATE_OPEN);

    for (int ph = 0; ph < 9; ph++) begin
      quiesce();
      case (ph)
        1: program_train(32'd2, 32'd3, 32'd5, 32'd3);
        2: program_train(32'd0, 32'd0, 32'd0, 32'd0);
        3: program_train(32'd1, 32'd2, 32'd1, 32'd4);
        4: program_train(32'hFFFF_FFFF, 32'd1, 32'd2, 32'h0000_FFFF);
        5: program_train(32'd3, 32'hFFFF_FFFF, 32'd0, 32'd2);
        6: program_train(32'd0, 32'd1, 32'd2, 32'h0000_FFFF);
        7: program_train($urandom_range(0, 4), $urandom_range(0, 3),
                         $urandom_range(0, 6), $urandom_range(0, 4));
        8: program_train(32'd1, 32'd1, 32'd3, 32'd2);
        default: begin
        end
      endcase
      case (ph % 4)
        0: begin
          sender_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 67;
          stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct = 67;
        end
        default: begin
          sender_idle_pct = 35;
          stall_pct = 35;
        end
      endcase
      for (int n = 0; n < 55; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
          cmd = CMD_TICK;
        end else if (pick < 92) begin
          cmd = CMD_START;
        end else if (pick < 96) begin
          cmd = CMD_STOP;
        end else begin
          cmd = CMD_NOP;
        end
        gv = $urandom_range(0, 1) ? GATE_OPEN : GATE_WIDTH'($urandom);
        send_word(cmd, 1'($urandom_range(0, 1)), gv);
      end
    end

    quiesce();
    repeat (8) @(negedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
